// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, sizes and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Operation codes.
  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_REMOVE   = 3'd1;
  localparam logic [2:0] OP_PEEK     = 3'd2;
  localparam logic [2:0] OP_EXISTS   = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;
  localparam logic [2:0] OP_INCREASE = 3'd5;
  localparam logic [2:0] OP_DECREASE = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOKEY = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        key;
    logic [31:0]        info;
    logic signed [31:0] priority_req;
    logic signed [31:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [31:0]        info_out;
    logic signed [31:0] priority_out;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        key;
    logic [31:0]        info;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } ctrl_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_HEAD_ISSUE,
    S_HEAD_USE,
    S_SHUP_ISSUE,
    S_SHUP_USE,
    S_FIND_ISSUE,
    S_FIND_USE,
    S_INS_ISSUE,
    S_INS_USE,
    S_INS_WRITE,
    S_DONE
  } ctrl_state_t;

endpackage

// ----- design/spq_store.sv -----
// ----------------------------------------------------------------------------
// spq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_store (
  input  logic              clk,
  input  spq_pkg::mem_req_t req,
  output spq_pkg::entry_t   rd_data
);
  import spq_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer that searches, shifts and places entries in the entry memory.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  spq_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               res_valid,
  output spq_pkg::out_item_t res_item,
  input  logic               res_taken,
  output spq_pkg::mem_req_t  mem_req,
  input  spq_pkg::entry_t    rd_data,
  output spq_pkg::ctrl_sts_t sts
);
  import spq_pkg::*;

  ctrl_state_t        state_r, state_nxt;
  logic [2:0]         op_r;
  logic [15:0]        key_r;
  logic [31:0]        info_r;
  logic signed [31:0] prio_r;
  logic signed [31:0] amount_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   count_r;
  logic [1:0]         status_r;
  logic               found_r;
  logic [31:0]        iout_r;
  logic signed [31:0] pout_r;

  logic [CNT_W-1:0]   idx_inc, idx_dec, cnt_dec;
  logic               is_full, is_empty, is_lookup, is_change;
  logic               key_match, find_last, shup_more, moves_down;
  logic signed [32:0] sum_w;
  logic signed [31:0] sat_w;

  // Shared conditions.
  assign idx_inc    = idx_r + CNT_W'(1);
  assign idx_dec    = idx_r - CNT_W'(1);
  assign cnt_dec    = count_r - CNT_W'(1);
  assign is_full    = (count_r == CNT_W'(CAPACITY));
  assign is_empty   = (count_r == '0);
  assign is_change  = (op_r == OP_INCREASE) || (op_r == OP_DECREASE);
  assign is_lookup  = (op_r == OP_EXISTS) || (op_r == OP_READ) || is_change;
  assign key_match  = (rd_data.key == key_r);
  assign find_last  = (idx_inc >= count_r);
  assign shup_more  = (idx_inc < count_r);
  assign moves_down = (rd_data.prio <= prio_r);

  // Saturating priority change.
  always_comb begin
    if (op_r == OP_INCREASE) begin
      sum_w = {rd_data.prio[31], rd_data.prio} + {amount_r[31], amount_r};
    end else begin
      sum_w = {rd_data.prio[31], rd_data.prio} - {amount_r[31], amount_r};
    end
    if (sum_w[32] != sum_w[31]) begin
      sat_w = sum_w[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_w = sum_w[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (op_r == OP_INSERT) begin
          if (is_full)       state_nxt = S_DONE;
          else if (is_empty) state_nxt = S_INS_WRITE;
          else               state_nxt = S_INS_ISSUE;
        end else if ((op_r == OP_REMOVE) || (op_r == OP_PEEK)) begin
          state_nxt = is_empty ? S_DONE : S_HEAD_ISSUE;
        end else if (is_lookup) begin
          state_nxt = is_empty ? S_DONE : S_FIND_ISSUE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_HEAD_ISSUE: state_nxt = S_HEAD_USE;
      S_HEAD_USE: begin
        state_nxt = (op_r == OP_REMOVE) ? S_SHUP_ISSUE : S_DONE;
      end
      S_SHUP_ISSUE: begin
        if (shup_more)              state_nxt = S_SHUP_USE;
        else if (op_r == OP_REMOVE) state_nxt = S_DONE;
        else if (cnt_dec == '0)     state_nxt = S_INS_WRITE;
        else                        state_nxt = S_INS_ISSUE;
      end
      S_SHUP_USE:   state_nxt = S_SHUP_ISSUE;
      S_FIND_ISSUE: state_nxt = S_FIND_USE;
      S_FIND_USE: begin
        if (key_match)      state_nxt = is_change ? S_SHUP_ISSUE : S_DONE;
        else if (find_last) state_nxt = S_DONE;
        else                state_nxt = S_FIND_ISSUE;
      end
      S_INS_ISSUE: state_nxt = S_INS_USE;
      S_INS_USE: begin
        if (moves_down) state_nxt = (idx_dec == '0) ? S_INS_WRITE : S_INS_ISSUE;
        else            state_nxt = S_INS_WRITE;
      end
      S_INS_WRITE: state_nxt = S_DONE;
      S_DONE: begin
        if (res_taken) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and memory requests.
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = rd_data;
    mem_req.waddr = idx_r[IDX_W-1:0];
    in_stall      = (state_r != S_IDLE);
    res_valid     = (state_r == S_DONE);
    unique case (state_r)
      S_HEAD_ISSUE: mem_req.raddr = '0;
      S_SHUP_ISSUE: mem_req.raddr = idx_inc[IDX_W-1:0];
      S_SHUP_USE:   mem_req.we    = 1'b1;
      S_FIND_ISSUE: mem_req.raddr = idx_r[IDX_W-1:0];
      S_INS_ISSUE:  mem_req.raddr = idx_dec[IDX_W-1:0];
      S_INS_USE:    mem_req.we    = moves_down;
      S_INS_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = '{key: key_r, info: info_r, prio: prio_r};
      end
      default: mem_req.raddr = '0;
    endcase
  end

  assign res_item = '{status: status_r, found: found_r, info_out: iout_r,
                      priority_out: pout_r};
  assign sts      = '{idle: (state_r == S_IDLE), count: count_r};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_SHUP_ISSUE) && !shup_more) count_r <= cnt_dec;
      if (state_r == S_INS_WRITE)                  count_r <= count_r + CNT_W'(1);
    end
  end

  // Item and result registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        op_r     <= in_data.operation;
        key_r    <= in_data.key;
        info_r   <= in_data.info;
        prio_r   <= in_data.priority_req;
        amount_r <= in_data.amount;
      end
      S_DISPATCH: begin
        status_r <= ST_OK;
        found_r  <= 1'b0;
        iout_r   <= '0;
        pout_r   <= '0;
        idx_r    <= (op_r == OP_INSERT) ? count_r : '0;
        if ((op_r == OP_INSERT) && is_full) status_r <= ST_FULL;
        if (((op_r == OP_REMOVE) || (op_r == OP_PEEK)) && is_empty) status_r <= ST_EMPTY;
        if (is_lookup && (op_r != OP_EXISTS) && is_empty) status_r <= ST_NOKEY;
      end
      S_HEAD_USE: begin
        iout_r <= rd_data.info;
        pout_r <= rd_data.prio;
        idx_r  <= '0;
      end
      S_SHUP_ISSUE: begin
        if (!shup_more) idx_r <= cnt_dec;
      end
      S_SHUP_USE: idx_r <= idx_inc;
      S_FIND_USE: begin
        if (key_match) begin
          if (op_r == OP_EXISTS) found_r <= 1'b1;
          if (op_r == OP_READ)   pout_r  <= rd_data.prio;
          if (is_change) begin
            info_r <= rd_data.info;
            prio_r <= sat_w;
            pout_r <= sat_w;
          end
        end else begin
          idx_r <= idx_inc;
          if (find_last && (op_r != OP_EXISTS)) status_r <= ST_NOKEY;
        end
      end
      S_INS_USE: begin
        if (moves_down) idx_r <= idx_dec;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-first priority queue kept as a sorted list in one memory.
// ----------------------------------------------------------------------------
// Usage:
// One operation beat enters on in_valid/in_data while in_stall is low and
// gives exactly one result beat on out_valid/out_data. Entries are kept in
// descending priority, newest first among equals, in a 64-entry memory.
// The sequencer takes one item at a time; each memory visit is a read
// issue followed by use of the registered read data. A finished result
// sits in the output register, so the next operation is taken while the
// receiver holds out_stall high; a stalled result stays unchanged. Reset
// empties the queue at once: the entry count is cleared, the memory
// itself is not swept.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  spq_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  output spq_pkg::out_item_t out_data,
  input  logic               out_stall
);
  import spq_pkg::*;

  mem_req_t  mem_req;
  entry_t    rd_data;
  ctrl_sts_t sts;
  logic      res_valid, res_taken, out_free;
  out_item_t res_item;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  spq_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_taken (res_taken),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .sts       (sts)
  );

  // Output register: takes a new result whenever it is empty or draining.
  assign out_free  = !out_valid_r || !out_stall;
  assign res_taken = res_valid && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_taken)     out_valid_nxt = 1'b1;
    else if (out_free) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) out_data_r <= res_item;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // An accepted beat leaves the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !sts.idle)
    else $error("sequencer idle after accepting a beat");

  // A result handed over shows on the output in the next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_taken |=> (out_valid && (out_data == $past(res_item))))
    else $error("result lost on hand-over");

  // A result that waits for the output register holds still.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_taken) |=> (res_valid && $stable(res_item)))
    else $error("waiting result changed");
`endif

endmodule

// ----- tb/tb_sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking testbench for the max-first sorted priority queue.
// A driver feeds operation beats from a pending queue with random gaps. A
// monitor takes result beats with random stalls and compares each one with
// the result worked out by a behavioural model of the queue.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  in_item_t  in_data;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall;

  sorted_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  // Model state of the queue, kept in descending priority order.
  entry_t    model_list[$];
  in_item_t  pending_ops[$];
  out_item_t expected_results[$];

  int  mismatch_count = 0;
  int  ops_sent = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  int  full_seen = 0;
  bit  stim_done = 0;
  bit  hold_off = 0;
  int  in_gap = 0;
  int  out_gap = 0;

  // Place an entry ahead of all entries of equal or lower priority.
  function automatic void model_place(entry_t e);
    int pos;
    pos = 0;
    while (pos < model_list.size() && model_list[pos].prio > e.prio) pos++;
    model_list.insert(pos, e);
  endfunction

  function automatic int model_find(logic [15:0] k);
    foreach (model_list[i]) if (model_list[i].key == k) return i;
    return -1;
  endfunction

  // Apply one operation to the model and return the result it gives.
  function automatic out_item_t queue_apply(in_item_t op);
    out_item_t r;
    entry_t    e;
    int        pos;
    longint    nv;
    r = '0;
    r.status = ST_OK;
    case (op.operation)
      OP_INSERT: begin
        if (model_list.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          e.key = op.key; e.info = op.info; e.prio = op.priority_req;
          model_place(e);
        end
      end
      OP_REMOVE, OP_PEEK: begin
        if (model_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.info_out = model_list[0].info;
          r.priority_out = model_list[0].prio;
          if (op.operation == OP_REMOVE) model_list.delete(0);
        end
      end
      OP_EXISTS: r.found = (model_find(op.key) >= 0);
      OP_READ: begin
        pos = model_find(op.key);
        if (pos < 0) r.status = ST_NOKEY;
        else r.priority_out = model_list[pos].prio;
      end
      OP_INCREASE, OP_DECREASE: begin
        pos = model_find(op.key);
        if (pos < 0) begin
          r.status = ST_NOKEY;
        end else begin
          e = model_list[pos];
          if (op.operation == OP_INCREASE)
            nv = longint'(e.prio) + longint'(op.amount);
          else
            nv = longint'(e.prio) - longint'(op.amount);
          if (nv > 64'sd2147483647) nv = 64'sd2147483647;
          if (nv < -64'sd2147483648) nv = -64'sd2147483648;
          e.prio = nv[31:0];
          r.priority_out = e.prio;
          model_list.delete(pos);
          model_place(e);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_op(logic [2:0] code, logic [15:0] k,
                                       logic [31:0] inf, logic [31:0] p,
                                       logic [31:0] a);
    in_item_t t;
    t.operation = code; t.key = k; t.info = inf;
    t.priority_req = p; t.amount = a;
    return t;
  endfunction

  // Random signed value, often near the extremes or in a narrow band.
  function automatic logic [31:0] rand_prio();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2, 3: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stimulus: directed cases first, then weighted random operations.
  initial begin
    logic [2:0] code;
    logic [15:0] k;
    pending_ops.push_back(make_op(OP_REMOVE, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_PEEK, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_READ, 16'hffff, '0, '0, '0));
    pending_ops.push_back(make_op(3'd7, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
    pending_ops.push_back(make_op(OP_INSERT, 16'h0000, 32'h0, 32'h7fffffff, '0));
    pending_ops.push_back(make_op(OP_INSERT, 16'hffff, 32'hffffffff, 32'h80000000, '0));
    pending_ops.push_back(make_op(OP_INSERT, 16'h1234, 32'h5555aaaa, 32'h7fffffff, '0));
    pending_ops.push_back(make_op(OP_INSERT, 16'h1234, 32'haaaa5555, 32'h0, '0));
    pending_ops.push_back(make_op(OP_EXISTS, 16'h1234, '0, '0, '0));
    pending_ops.push_back(make_op(OP_EXISTS, 16'h4321, '0, '0, '0));
    pending_ops.push_back(make_op(OP_INCREASE, 16'h0000, '0, '0, 32'h7fffffff));
    pending_ops.push_back(make_op(OP_DECREASE, 16'hffff, '0, '0, 32'h7fffffff));
    pending_ops.push_back(make_op(OP_INCREASE, 16'hffff, '0, '0, 32'h80000000));
    pending_ops.push_back(make_op(OP_DECREASE, 16'h1234, '0, '0, 32'h80000000));
    pending_ops.push_back(make_op(OP_INCREASE, 16'h7777, '0, '0, 32'd1));
    pending_ops.push_back(make_op(OP_DECREASE, 16'h7777, '0, '0, 32'd1));
    pending_ops.push_back(make_op(OP_READ, 16'h1234, '0, '0, '0));
    pending_ops.push_back(make_op(OP_PEEK, '0, '0, '0, '0));
    for (int i = 0; i < 6; i++) pending_ops.push_back(make_op(OP_REMOVE, '0, '0, '0, '0));
    // Fill the queue past capacity so that inserts are refused.
    for (int i = 0; i < CAPACITY + 4; i++)
      pending_ops.push_back(make_op(OP_INSERT, 16'($urandom_range(0, 31)), $urandom,
                                    rand_prio(), '0));
    // Random mix; keys drawn from a small pool so lookups usually hit.
    for (int i = 0; i < 1150; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: code = OP_INSERT;
        5, 6, 7: code = OP_REMOVE;
        8: code = OP_PEEK;
        9, 10: code = OP_EXISTS;
        11, 12: code = OP_READ;
        13, 14, 15: code = OP_INCREASE;
        16, 17, 18: code = OP_DECREASE;
        default: code = 3'd7;
      endcase
      k = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
      pending_ops.push_back(make_op(code, k, $urandom, rand_prio(), rand_prio()));
    end
  end

  // Reset, then one long receiver hold-off while the sender keeps going.
  initial begin
    rst_n = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    repeat ($urandom_range(300, 600)) @(posedge clk);
    hold_off <= 1;
    repeat (2000) @(posedge clk);
    hold_off <= 0;
  end

  // Driver: offer the next pending beat after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data  <= '0;
      in_gap   = $urandom_range(0, 10);
    end else if (in_valid && !in_stall) begin
      expected_results.push_back(queue_apply(in_data));
      ops_sent++;
      in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (in_gap == 0 && pending_ops.size() > 0) begin
        in_data <= pending_ops.pop_front();
      end else begin
        in_valid <= 0;
        if (pending_ops.size() == 0) stim_done <= 1;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
      end else if (pending_ops.size() > 0) begin
        in_valid <= 1;
        in_data  <= pending_ops.pop_front();
      end else begin
        stim_done <= 1;
      end
    end
  end

  // Monitor: stall at random and compare every accepted result beat.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_stall <= 0;
      out_gap   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat %p", out_data);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.status == ST_FULL) full_seen++;
          if (out_data.status !== exp_r.status || out_data.found !== exp_r.found ||
              out_data.info_out !== exp_r.info_out ||
              out_data.priority_out !== exp_r.priority_out) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected st=%0d fd=%0d info=%h pr=%0d, got st=%0d fd=%0d info=%h pr=%0d",
                       results_seen, exp_r.status, exp_r.found, exp_r.info_out,
                       exp_r.priority_out, out_data.status, out_data.found,
                       out_data.info_out, out_data.priority_out);
          end
        end
        out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
      end
      out_stall <= hold_off || (out_gap > 0);
    end
  end

  // Watchdog on accepted beats on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 expected_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // End of run: drain, let the design settle, then report.
  initial begin
    wait (rst_n === 1'b1);
    wait (stim_done && !in_valid && expected_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("Ran %0d operations with %0d results checked; %0d inserts were refused as full.",
             ops_sent, results_seen, full_seen);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
